/* hw/rtl/psf_pkg.sv */
// types and constants shared by the polygon streamfunction flux block
// no dependencies; imported by psf_divsqrt and polygon_streamfunction_flux
`default_nettype none

package psf_pkg;

  // shared multiplier operand and product widths
  localparam int MULW  = 32;
  localparam int PRODW = 64;
  // width of the iteration count handed to the divide/root unit
  localparam int ITW   = 6;
  // width of the wide datapath words in the divide/root unit
  localparam int DATAW = 64;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MSQ,
    ST_MACC,
    ST_MSQRT_GO,
    ST_MSQRT_WAIT,
    ST_EDGE,
    ST_U0_GO,
    ST_U0_WAIT,
    ST_U1_GO,
    ST_U1_WAIT,
    ST_WSQ,
    ST_WACC,
    ST_WSQRT_GO,
    ST_WSQRT_WAIT,
    ST_A_MUL,
    ST_A_GO,
    ST_A_WAIT,
    ST_D_MUL,
    ST_D_ACC,
    ST_EDGE_END,
    ST_POST
  } psf_state_t;

  // command to the divide/root unit
  typedef struct packed {
    logic           start;
    logic           is_sqrt;
    logic [ITW-1:0] iters;
  } psf_cmd_t;

  // status from the divide/root unit
  typedef struct packed {
    logic done;
    logic rem_nz;
  } psf_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/psf_divsqrt.sv */
// shared iterative unit: restoring division or integer square root, one bit a cycle
// depends on psf_pkg
`default_nettype none

module psf_divsqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  psf_pkg::psf_cmd_t           cmd,
  input  logic [psf_pkg::DATAW-1:0]   num,
  input  logic [psf_pkg::DATAW-1:0]   den,
  output psf_pkg::psf_stat_t          stat,
  output logic [psf_pkg::DATAW-1:0]   result
);
  import psf_pkg::*;

  logic [DATAW-1:0] rem;
  logic [DATAW-1:0] acc;
  logic [DATAW-1:0] step;
  logic [ITW-1:0]   cnt;
  logic             busy;
  logic             done;
  logic             mode;
  logic [DATAW-1:0] trial;
  logic             fits;

  // trial subtrahend: shifted divisor, or root plus current bit pair
  assign trial = mode ? (acc + step) : step;
  assign fits  = (rem >= trial);

  // iteration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.iters;
        mode <= cmd.is_sqrt;
        rem  <= num;
        acc  <= '0;
        if (cmd.is_sqrt) begin
          step <= DATAW'(1) << ({cmd.iters, 1'b0} - (ITW+1)'(2));
        end else begin
          step <= den << (cmd.iters - ITW'(1));
        end
      end else if (busy) begin
        if (fits) begin
          rem <= rem - trial;
          acc <= mode ? ((acc >> 1) + step) : {acc[DATAW-2:0], 1'b1};
        end else begin
          acc <= mode ? (acc >> 1) : {acc[DATAW-2:0], 1'b0};
        end
        step <= mode ? (step >> 2) : (step >> 1);
        cnt  <= cnt - ITW'(1);
        if (cnt == ITW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // status and result
  assign stat.done   = done;
  assign stat.rem_nz = (rem != '0);
  assign result      = acc;

endmodule

`default_nettype wire

/* hw/rtl/polygon_streamfunction_flux.sv */
// top level of the polygon streamfunction flux block: sequencer and datapath
// depends on psf_pkg and psf_divsqrt
//
// usage: vertices of one face arrive in order on the input channel
// (in_valid/in_ready), one word per vertex with position, streamfunction
// vector and final_vertex. a word marked final_vertex closes the face, and
// one result word (face_flux, degenerate) follows on the output channel
// (out_valid/out_ready). other words give no result.
// each vertex runs through one shared divide/square-root unit that retires
// one bit a cycle, plus one 32x32 multiplier. a vertex first takes the root
// of its squared stream magnitude; each edge then takes two unit divides and
// a square per component, one root, and per component a product, a divide
// and a product. a final vertex also runs the closing edge to the first one.
// in_ready is high only while the sequencer is idle.
// the result sits in an output register; a stalled receiver does not stop
// the next face until a new result has to be loaded over an untaken one.
// reset clears the face state and drops out_valid; no clearing pass.
`default_nettype none

module polygon_streamfunction_flux #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 22
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic signed [COORD_WIDTH-1:0] stream_x,
  input  logic signed [COORD_WIDTH-1:0] stream_y,
  input  logic signed [COORD_WIDTH-1:0] stream_z,
  input  logic                          final_vertex,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [63:0]            face_flux,
  output logic                          degenerate
);
  import psf_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int MW = COORD_WIDTH + 1;  // vector magnitude and magnitude sum
  localparam int WW = FRAC_BITS + 3;    // signed sum of two unit components
  localparam int NW = FRAC_BITS + 2;    // magnitude of that sum
  localparam int AW = COORD_WIDTH + 1;  // averaged component magnitude
  localparam int DW = COORD_WIDTH + 1;  // position difference

  localparam logic [ITW-1:0] IT_MAG = ITW'(COORD_WIDTH);
  localparam logic [ITW-1:0] IT_U   = ITW'(FRAC_BITS + 1);
  localparam logic [ITW-1:0] IT_W   = ITW'(FRAC_BITS + 2);
  localparam logic [ITW-1:0] IT_A   = ITW'(COORD_WIDTH + 1);

  psf_state_t state, state_next;

  logic signed [W-1:0]  cur_p [3];
  logic signed [W-1:0]  cur_s [3];
  logic signed [W-1:0]  first_p [3];
  logic signed [W-1:0]  first_s [3];
  logic signed [W-1:0]  prev_p [3];
  logic signed [W-1:0]  prev_s [3];
  logic [MW-1:0]        cur_m;
  logic [MW-1:0]        first_m;
  logic [MW-1:0]        prev_m;
  logic signed [WW-1:0] w [3];
  logic signed [WW-1:0] u0;
  logic [NW-1:0]        nw;
  logic [AW-1:0]        a_mag;
  logic [PRODW-1:0]     acc;
  logic [PRODW-1:0]     prod;
  logic [63:0]          flux_sum;
  logic [1:0]           c;
  logic                 closing;
  logic                 last;
  logic                 have_first;
  logic                 deg_seen;

  // edge operand selection
  logic signed [W-1:0]  p0, p1, s0, s1;
  logic [MW-1:0]        m0, m1, msum;
  logic [W-1:0]         s0_mag, s1_mag, cs_mag;
  logic signed [WW-1:0] wc;
  logic [NW-1:0]        w_mag;
  logic signed [DW-1:0] d;
  logic [DW-1:0]        d_mag;
  logic                 edge_zero;

  // shared unit hookup
  psf_cmd_t             cmd;
  psf_stat_t            stat;
  logic [DATAW-1:0]     div_num, div_den, div_res, sq_res;
  logic signed [WW-1:0] q_signed;
  logic [MULW-1:0]      mul_a, mul_b;
  logic                 in_acc, out_free;

  assign in_acc   = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  assign p0 = closing ? cur_p[c]   : prev_p[c];
  assign p1 = closing ? first_p[c] : cur_p[c];
  assign s0 = closing ? cur_s[c]   : prev_s[c];
  assign s1 = closing ? first_s[c] : cur_s[c];
  assign m0 = closing ? cur_m      : prev_m;
  assign m1 = closing ? first_m    : cur_m;
  assign msum = m0 + m1;
  assign edge_zero = (m0 == '0) | (m1 == '0);

  assign s0_mag = s0[W-1] ? W'(-s0) : W'(s0);
  assign s1_mag = s1[W-1] ? W'(-s1) : W'(s1);
  assign cs_mag = cur_s[c][W-1] ? W'(-cur_s[c]) : W'(cur_s[c]);
  assign wc     = w[c];
  assign w_mag  = wc[WW-1] ? NW'(-wc) : NW'(wc);
  assign d      = DW'(p0) - DW'(p1);
  assign d_mag  = d[DW-1] ? DW'(-d) : DW'(d);

  // ceiling root from floor root and leftover
  assign sq_res = div_res + DATAW'(stat.rem_nz);

  // rounded unit component, signed by the active stream component
  always_comb begin
    if (state == ST_U0_WAIT) begin
      q_signed = s0[W-1] ? -WW'(div_res) : WW'(div_res);
    end else begin
      q_signed = s1[W-1] ? -WW'(div_res) : WW'(div_res);
    end
  end

  psf_divsqrt u_divsqrt (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .num    (div_num),
    .den    (div_den),
    .stat   (stat),
    .result (div_res)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, unit commands and multiplier operands
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.start   = 1'b0;
    cmd.is_sqrt = 1'b0;
    cmd.iters   = IT_U;
    div_num     = '0;
    div_den     = '0;
    mul_a       = '0;
    mul_b       = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_MSQ;
      end
      ST_MSQ: begin
        mul_a      = MULW'(cs_mag);
        mul_b      = MULW'(cs_mag);
        state_next = ST_MACC;
      end
      ST_MACC: begin
        state_next = (c == 2'd2) ? ST_MSQRT_GO : ST_MSQ;
      end
      ST_MSQRT_GO: begin
        cmd.start   = 1'b1;
        cmd.is_sqrt = 1'b1;
        cmd.iters   = IT_MAG;
        div_num     = acc;
        state_next  = ST_MSQRT_WAIT;
      end
      ST_MSQRT_WAIT: begin
        if (stat.done) state_next = have_first ? ST_EDGE : ST_POST;
      end
      ST_EDGE: begin
        state_next = edge_zero ? ST_EDGE_END : ST_U0_GO;
      end
      ST_U0_GO: begin
        cmd.start  = 1'b1;
        cmd.iters  = IT_U;
        div_num    = (DATAW'(s0_mag) << FRAC_BITS) + DATAW'(m0 >> 1);
        div_den    = DATAW'(m0);
        state_next = ST_U0_WAIT;
      end
      ST_U0_WAIT: begin
        if (stat.done) state_next = ST_U1_GO;
      end
      ST_U1_GO: begin
        cmd.start  = 1'b1;
        cmd.iters  = IT_U;
        div_num    = (DATAW'(s1_mag) << FRAC_BITS) + DATAW'(m1 >> 1);
        div_den    = DATAW'(m1);
        state_next = ST_U1_WAIT;
      end
      ST_U1_WAIT: begin
        if (stat.done) state_next = ST_WSQ;
      end
      ST_WSQ: begin
        mul_a      = MULW'(w_mag);
        mul_b      = MULW'(w_mag);
        state_next = ST_WACC;
      end
      ST_WACC: begin
        state_next = (c == 2'd2) ? ST_WSQRT_GO : ST_U0_GO;
      end
      ST_WSQRT_GO: begin
        cmd.start   = 1'b1;
        cmd.is_sqrt = 1'b1;
        cmd.iters   = IT_W;
        div_num     = acc;
        state_next  = ST_WSQRT_WAIT;
      end
      ST_WSQRT_WAIT: begin
        if (stat.done) state_next = (sq_res == '0) ? ST_EDGE_END : ST_A_MUL;
      end
      ST_A_MUL: begin
        mul_a      = MULW'(w_mag);
        mul_b      = MULW'(msum);
        state_next = ST_A_GO;
      end
      ST_A_GO: begin
        cmd.start  = 1'b1;
        cmd.iters  = IT_A;
        div_num    = prod + DATAW'(nw);
        div_den    = DATAW'({nw, 1'b0});
        state_next = ST_A_WAIT;
      end
      ST_A_WAIT: begin
        if (stat.done) state_next = ST_D_MUL;
      end
      ST_D_MUL: begin
        mul_a      = MULW'(a_mag);
        mul_b      = MULW'(d_mag);
        state_next = ST_D_ACC;
      end
      ST_D_ACC: begin
        state_next = (c == 2'd2) ? ST_EDGE_END : ST_A_MUL;
      end
      ST_EDGE_END: begin
        if (!closing) state_next = ST_POST;
        else if (out_free) state_next = ST_IDLE;
      end
      ST_POST: begin
        state_next = last ? ST_EDGE : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // result word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EDGE_END && closing && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // face state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      have_first <= 1'b0;
      deg_seen   <= 1'b0;
      flux_sum   <= '0;
      closing    <= 1'b0;
      last       <= 1'b0;
      c          <= '0;
      for (int i = 0; i < 3; i++) begin
        first_p[i] <= '0;
        first_s[i] <= '0;
        prev_p[i]  <= '0;
        prev_s[i]  <= '0;
      end
      first_m <= '0;
      prev_m  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            cur_p[0] <= point_x;
            cur_p[1] <= point_y;
            cur_p[2] <= point_z;
            cur_s[0] <= stream_x;
            cur_s[1] <= stream_y;
            cur_s[2] <= stream_z;
            last     <= final_vertex;
            closing  <= 1'b0;
            c        <= '0;
            acc      <= '0;
          end
        end
        ST_MACC, ST_WACC: begin
          acc <= acc + prod;
          c   <= (c == 2'd2) ? 2'd0 : c + 2'd1;
        end
        ST_MSQRT_WAIT: begin
          if (stat.done) begin
            cur_m <= MW'(sq_res);
            if (!have_first) begin
              first_p    <= cur_p;
              first_s    <= cur_s;
              first_m    <= MW'(sq_res);
              have_first <= 1'b1;
            end
          end
        end
        ST_EDGE: begin
          if (edge_zero) deg_seen <= 1'b1;
          c   <= '0;
          acc <= '0;
        end
        ST_U0_WAIT: begin
          if (stat.done) u0 <= q_signed;
        end
        ST_U1_WAIT: begin
          if (stat.done) w[c] <= u0 + q_signed;
        end
        ST_WSQRT_WAIT: begin
          if (stat.done) begin
            nw <= NW'(sq_res);
            if (sq_res == '0) deg_seen <= 1'b1;
            c  <= '0;
          end
        end
        ST_A_WAIT: begin
          if (stat.done) a_mag <= AW'(div_res);
        end
        ST_D_ACC: begin
          flux_sum <= (wc[WW-1] ^ d[DW-1]) ? (flux_sum - prod) : (flux_sum + prod);
          c        <= (c == 2'd2) ? 2'd0 : c + 2'd1;
        end
        ST_EDGE_END: begin
          if (closing && out_free) begin
            face_flux  <= flux_sum;
            degenerate <= deg_seen;
            flux_sum   <= '0;
            deg_seen   <= 1'b0;
            have_first <= 1'b0;
          end
        end
        ST_POST: begin
          prev_p <= cur_p;
          prev_s <= cur_s;
          prev_m <= cur_m;
          if (last) closing <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/psf_check.sv */
// port-level assertions for the polygon streamfunction flux block
// bound to polygon_streamfunction_flux; no package dependency
`default_nettype none

module psf_check #(
  parameter int COORD_WIDTH = 24
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [COORD_WIDTH-1:0] point_x,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [63:0]            face_flux,
  input logic                   degenerate
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(face_flux) && $stable(degenerate))
    else $error("result word changed while stalled");

  // the sequencer stays busy in the cycle after it accepts a vertex
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // a result appears only as the sequencer finishes a face
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word raised while idle");

  // reset drops the result word
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid after reset");

  // input position stays put while waiting
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> $stable(point_x))
    else $error("input word changed while stalled");

endmodule

bind polygon_streamfunction_flux psf_check #(.COORD_WIDTH(COORD_WIDTH)) u_psf_check (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .point_x    (point_x),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .face_flux  (face_flux),
  .degenerate (degenerate)
);

`default_nettype wire
